/* rtl/knob_smoothing_change_detector_assert.svh */
// Assertion shorthands used by the checker file.
// Both expect clk and arst_n in scope; checks are off while reset is held.
`ifndef KNOB_SMOOTHING_CHANGE_DETECTOR_ASSERT_SVH
`define KNOB_SMOOTHING_CHANGE_DETECTOR_ASSERT_SVH

// same-cycle implication
`define KSCD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kscd check failed");

// next-cycle implication
`define KSCD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kscd check failed");

`endif

/* rtl/kscd_pkg.sv */
`timescale 1ns / 1ps

package kscd_pkg;

	// design size
	localparam int CHANNELS      = 8;
	localparam int FRACTION_BITS = 12;

	// fixed field widths
	localparam int CHAN_W     = 3;
	localparam int SAMPLE_W   = 12;
	localparam int KNOB_W     = 24;
	localparam int ALPHA_W    = 16;
	localparam int THRESH_W   = 24;
	localparam int COUNT_W    = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	// filter arithmetic
	localparam int ALPHA_SHIFT = 16;
	localparam int VAL_W       = SAMPLE_W + FRACTION_BITS;
	localparam int CMP_W       = (VAL_W > THRESH_W) ? VAL_W : THRESH_W;
	localparam int PROD_W      = VAL_W + ALPHA_W + 2;
	localparam int STEP_W      = PROD_W - ALPHA_SHIFT;
	localparam int CH_IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// front-to-back queue
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COUNT     = 2'd2;

	// register reset values
	localparam logic [ALPHA_W-1:0]  ALPHA_RST  = 16'd6554;
	localparam logic [THRESH_W-1:0] THRESH_RST = 24'd167936;
	localparam logic [COUNT_W-1:0]  COUNT_RST  = 4'd8;

	// largest knob value seen on the port
	localparam logic [VAL_W-1:0] VAL_MAX = {{SAMPLE_W{1'b1}}, {FRACTION_BITS{1'b0}}};
	localparam logic [KNOB_W-1:0] KNOB_MAX = (VAL_W > KNOB_W) ? {KNOB_W{1'b1}} :
		KNOB_W'(VAL_MAX);

	typedef logic [CHAN_W-1:0]   chan_t;
	typedef logic [CH_IDX_W-1:0] ch_idx_t;
	typedef logic [VAL_W-1:0]    value_t;

	typedef struct packed {
		chan_t               channel;
		logic [SAMPLE_W-1:0] raw_sample;
		logic                queue_ready;
	} sample_word_t;

	typedef struct packed {
		chan_t             knob_channel;
		logic [KNOB_W-1:0] knob_value;
	} knob_word_t;

	// settings the back end needs
	typedef struct packed {
		logic [ALPHA_W-1:0]  alpha;
		logic [THRESH_W-1:0] threshold;
	} back_cfg_t;

	// queue head as seen by the back end
	typedef struct packed {
		logic         valid;
		sample_word_t word;
	} q_head_t;

endpackage

/* rtl/knob_smoothing_change_detector.sv */
`timescale 1ns / 1ps

// Per-channel knob smoother with change reporting. Each sample word carries a channel, a
// 12-bit converter reading and the downstream queue_ready flag; the channel's Q12.12 filter
// value moves toward the reading by alpha/65536 (floor rounding), and a knob word goes out
// when the channel was never reported or the filter value moved strictly more than the
// threshold from the last reported value, and only if queue_ready was set. Samples for
// channels at or above channel_count are taken and dropped. Rate: one sample per cycle
// while the result register is free, except that a sample for the same channel as the one
// in the evaluate stage waits until that stage moves on, since that channel's filter value
// is read, multiplied and written back through a two-stage loop (multiply on queue pop, add
// and compare in the evaluate stage). A two-entry queue between the input and the filter
// lets each side stall on its own. The user must write configuration only while the block
// is idle; the block itself does not enforce this.
module knob_smoothing_change_detector import kscd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sample_valid,
	output logic                  sample_stall,
	input  sample_word_t          sample,
	output logic                  knob_valid,
	input  logic                  knob_stall,
	output knob_word_t            knob,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [ALPHA_W-1:0]  alpha_q;
	logic [THRESH_W-1:0] thresh_q;
	logic [COUNT_W-1:0]  count_q;

	back_cfg_t    back_cfg;
	logic         push;
	sample_word_t push_word;
	logic         q_full;
	q_head_t      head;
	logic         pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q  <= ALPHA_RST;
			thresh_q <= THRESH_RST;
			count_q  <= COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ALPHA:     alpha_q  <= cfg_data[ALPHA_W-1:0];
				CFG_THRESHOLD: thresh_q <= cfg_data[THRESH_W-1:0];
				CFG_COUNT:     count_q  <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign back_cfg.alpha     = alpha_q;
	assign back_cfg.threshold = thresh_q;

	kscd_front u_front (
		.sample_valid  (sample_valid),
		.sample_stall  (sample_stall),
		.sample        (sample),
		.channel_count (count_q),
		.q_full        (q_full),
		.push          (push),
		.push_word     (push_word)
	);

	kscd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.full      (q_full),
		.head      (head),
		.pop       (pop)
	);

	kscd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (back_cfg),
		.head       (head),
		.pop        (pop),
		.knob_valid (knob_valid),
		.knob_stall (knob_stall),
		.knob       (knob)
	);

endmodule

/* rtl/kscd_front.sv */
`timescale 1ns / 1ps

module kscd_front import kscd_pkg::*; (
	input  logic               sample_valid,
	output logic               sample_stall,
	input  sample_word_t       sample,
	input  logic [COUNT_W-1:0] channel_count,
	input  logic               q_full,
	output logic               push,
	output sample_word_t       push_word
);

	logic in_range;

	// samples for unused channels are taken and dropped here
	assign in_range = (int'(sample.channel) < int'(channel_count)) &&
		(int'(sample.channel) < CHANNELS);

	assign sample_stall = q_full;
	assign push         = sample_valid && !q_full && in_range;
	assign push_word    = sample;

endmodule

/* rtl/kscd_queue.sv */
`timescale 1ns / 1ps

module kscd_queue import kscd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  sample_word_t push_word,
	output logic         full,
	output q_head_t      head,
	input  logic         pop
);

	sample_word_t      entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.word  = entry_q[rd_ptr_q];

	// storage, no reset needed
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_word;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/kscd_back.sv */
`timescale 1ns / 1ps

module kscd_back import kscd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  back_cfg_t  cfg,
	input  q_head_t    head,
	output logic       pop,
	output logic       knob_valid,
	input  logic       knob_stall,
	output knob_word_t knob
);

	// per-channel state
	value_t              filt_q [CHANNELS];
	value_t              last_q [CHANNELS];
	logic [CHANNELS-1:0] sent_q;

	// evaluate stage
	logic                     s1_valid_q;
	chan_t                    chan_s1;
	logic                     ready_s1;
	value_t                   cur_s1;
	logic signed [STEP_W-1:0] step_s1;

	// result register
	logic       out_valid_q;
	knob_word_t out_word_q;

	ch_idx_t                  head_idx;
	ch_idx_t                  idx_s1;
	value_t                   head_cur;
	value_t                   target;
	logic signed [VAL_W:0]    diff;
	logic signed [PROD_W-1:0] prod;
	logic signed [STEP_W-1:0] sum;
	value_t                   new_cur;
	value_t                   last_cur;
	value_t                   gap;
	logic                     over;
	logic                     send;
	logic                     out_free;
	logic                     hazard;
	logic                     s1_take;

	assign head_idx = ch_idx_t'(head.word.channel);
	assign idx_s1   = ch_idx_t'(chan_s1);

	// result register frees when empty or being taken
	assign out_free = !out_valid_q || !knob_stall;
	assign s1_take  = !s1_valid_q || out_free;

	// same channel in evaluate: filter value not written back yet
	assign hazard = s1_valid_q && (chan_s1 == head.word.channel);
	assign pop    = head.valid && !hazard && s1_take;

	// pop stage: step = floor(alpha * (target - cur) / 2^16)
	assign head_cur = filt_q[head_idx];
	assign target   = {head.word.raw_sample, {FRACTION_BITS{1'b0}}};
	assign diff     = $signed({1'b0, target}) - $signed({1'b0, head_cur});
	assign prod     = $signed({1'b0, cfg.alpha}) * diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s1_take) begin
			s1_valid_q <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			chan_s1  <= head.word.channel;
			ready_s1 <= head.word.queue_ready;
			cur_s1   <= head_cur;
			step_s1  <= prod[PROD_W-1:ALPHA_SHIFT];
		end
	end

	// evaluate stage: new filter value and dead-band test
	assign sum      = $signed({2'b00, cur_s1}) + step_s1;
	assign new_cur  = sum[VAL_W-1:0];
	assign last_cur = last_q[idx_s1];
	assign gap      = (new_cur >= last_cur) ? (new_cur - last_cur) : (last_cur - new_cur);
	assign over     = CMP_W'(gap) > CMP_W'(cfg.threshold);
	assign send     = s1_valid_q && out_free && ready_s1 && (!sent_q[idx_s1] || over);

	// channel state write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				filt_q[i] <= '0;
				last_q[i] <= '0;
			end
			sent_q <= '0;
		end else begin
			if (s1_valid_q && out_free) begin
				filt_q[idx_s1] <= new_cur;
			end
			if (send) begin
				last_q[idx_s1] <= new_cur;
				sent_q[idx_s1] <= 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= send;
		end
	end

	always_ff @(posedge clk) begin
		if (send) begin
			out_word_q.knob_channel <= chan_s1;
			out_word_q.knob_value   <= KNOB_W'(new_cur);
		end
	end

	assign knob_valid = out_valid_q;
	assign knob       = out_word_q;

endmodule

/* rtl/kscd_checker.sv */
`timescale 1ns / 1ps
`include "knob_smoothing_change_detector_assert.svh"

module kscd_checker import kscd_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       knob_valid,
	input logic       knob_stall,
	input knob_word_t knob
);

	// a stalled word stays put
	`KSCD_ASSERT_NXT(a_knob_hold, knob_valid && knob_stall, knob_valid)
	`KSCD_ASSERT_NXT(a_knob_stable, knob_valid && knob_stall, $stable(knob))

	// filter never leaves the scaled converter range
	`KSCD_ASSERT_IMP(a_knob_range, knob_valid, knob.knob_value <= KNOB_MAX)

	// dead-band: a channel reported twice in a row must have moved
	`KSCD_ASSERT_NXT(a_no_repeat, knob_valid && !knob_stall && (VAL_W <= KNOB_W), !(knob_valid && (knob.knob_channel == $past(knob.knob_channel)) && (knob.knob_value == $past(knob.knob_value))))

endmodule

bind knob_smoothing_change_detector kscd_checker u_kscd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.knob_valid (knob_valid),
	.knob_stall (knob_stall),
	.knob       (knob)
);

/* tb/tb_knob_smoothing_change_detector.sv */
`timescale 1ns / 1ps

module tb_knob_smoothing_change_detector import kscd_pkg::*; ();

	// Tracks per-channel filter state and the knob words the block owes us
	class knob_scoreboard;
		int unsigned alpha;
		int unsigned threshold;
		int unsigned count;
		value_t      filt[CHANNELS];
		value_t      prev_reported[CHANNELS];
		bit          ever_sent[CHANNELS];
		knob_word_t  owed_knobs[$];
		int unsigned errors;

		function new();
			alpha     = ALPHA_RST;
			threshold = THRESH_RST;
			count     = COUNT_RST;
			errors    = 0;
			for (int i = 0; i < CHANNELS; i++) begin
				filt[i]          = '0;
				prev_reported[i] = '0;
				ever_sent[i]     = 1'b0;
			end
		endfunction

		function void configure(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_ALPHA: begin
					alpha = data[ALPHA_W-1:0];
				end
				CFG_THRESHOLD: begin
					threshold = data[THRESH_W-1:0];
				end
				CFG_COUNT: begin
					count = data[COUNT_W-1:0];
				end
				default: begin
				end
			endcase
		endfunction

		// Advance one channel's filter and queue a knob word if it should go out
		function void smooth_sample(sample_word_t w);
			int unsigned ch;
			longint      target;
			longint      cur;
			longint      diff;
			knob_word_t  k;
			ch = w.channel;
			if (ch >= count || ch >= CHANNELS)
				return;
			target = longint'(w.raw_sample) << FRACTION_BITS;
			cur    = filt[ch];
			// floor rounding on both sides: the step down rounds its magnitude up
			if (target >= cur)
				cur = cur + ((longint'(alpha) * (target - cur)) >> ALPHA_SHIFT);
			else
				cur = cur - ((longint'(alpha) * (cur - target) + 65535) >> ALPHA_SHIFT);
			filt[ch] = value_t'(cur);
			diff = (cur >= longint'(prev_reported[ch])) ? cur - longint'(prev_reported[ch]) :
				longint'(prev_reported[ch]) - cur;
			if (ever_sent[ch] && diff <= longint'(threshold))
				return;
			// blocked downstream: nothing goes out and last-sent stays for a retry
			if (!w.queue_ready)
				return;
			prev_reported[ch] = value_t'(cur);
			ever_sent[ch]     = 1'b1;
			k.knob_channel = chan_t'(ch);
			k.knob_value   = KNOB_W'(cur);
			owed_knobs.push_back(k);
		endfunction

		function void check_knob(knob_word_t k);
			knob_word_t exp_k;
			if (owed_knobs.size() == 0) begin
				errors++;
				$display("%0t: knob word with none expected: channel %0d value %0h",
					$time, k.knob_channel, k.knob_value);
				return;
			end
			exp_k = owed_knobs.pop_front();
			if (k.knob_channel !== exp_k.knob_channel) begin
				errors++;
				$display("%0t: knob_channel expected %0d actual %0d",
					$time, exp_k.knob_channel, k.knob_channel);
			end
			if (k.knob_value !== exp_k.knob_value) begin
				errors++;
				$display("%0t: knob_value expected %0h actual %0h",
					$time, exp_k.knob_value, k.knob_value);
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  sample_valid = 1'b0;
	logic                  sample_stall;
	sample_word_t          sample = '0;
	logic                  knob_valid;
	logic                  knob_stall = 1'b0;
	knob_word_t            knob;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	knob_scoreboard sb;
	bit             quiet = 1'b0;
	int unsigned    stall_left = 0;
	int unsigned    aim[CHANNELS];

	knob_smoothing_change_detector uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.knob_valid   (knob_valid),
		.knob_stall   (knob_stall),
		.knob         (knob),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// downstream stall in random bursts, none once the run goes quiet
	always @(negedge clk) begin
		if (quiet) begin
			knob_stall <= 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			knob_stall <= 1'b1;
			stall_left--;
		end else if ($urandom_range(0, 9) == 0) begin
			knob_stall <= 1'b1;
			stall_left = $urandom_range(1, 15) - 1;
		end else begin
			knob_stall <= 1'b0;
		end
	end

	// output monitor
	always @(posedge clk) begin
		if (arst_n && knob_valid && !knob_stall)
			sb.check_knob(knob);
	end

	initial begin
		#2_000_000;
		$display("knob_smoothing_change_detector verification failed");
		$finish;
	end

	function automatic sample_word_t mk(int unsigned ch, int unsigned raw, bit rdy);
		sample_word_t w;
		w.channel     = chan_t'(ch);
		w.raw_sample  = raw[SAMPLE_W-1:0];
		w.queue_ready = rdy;
		return w;
	endfunction

	// Mostly slow drifts around a per-channel level, with jumps, rails and noise
	function automatic sample_word_t pick_sample(int unsigned cnt);
		int unsigned ch;
		int unsigned mode;
		int          raw;
		if (cnt > 0 && $urandom_range(0, 6) != 0)
			ch = $urandom_range(0, (cnt > CHANNELS ? CHANNELS : cnt) - 1);
		else
			ch = $urandom_range(0, CHANNELS - 1);
		mode = $urandom_range(0, 99);
		if (mode < 10) begin
			raw = $urandom_range(0, 1) ? 4095 : 0;
		end else if (mode < 25) begin
			raw = $urandom_range(0, 4095);
		end else begin
			if ($urandom_range(0, 15) == 0)
				aim[ch] = $urandom_range(0, 4095);
			raw = int'(aim[ch]) + int'($urandom_range(0, 16)) - 8;
			if (raw < 0)
				raw = 0;
			if (raw > 4095)
				raw = 4095;
		end
		return mk(ch, raw, $urandom_range(0, 4) != 0);
	endfunction

	// Entered and left just after a falling edge
	task automatic send_word(sample_word_t w);
		sample_valid <= 1'b1;
		sample       <= w;
		do
			@(posedge clk);
		while (sample_stall);
		sb.smooth_sample(w);
		@(negedge clk);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
	endtask

	// drain every owed word, then let in-flight dropped samples pass
	task automatic settle();
		sample_valid <= 1'b0;
		while (sb.owed_knobs.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_regs(int unsigned alpha, int unsigned thresh, int unsigned cnt);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_ALPHA;
		cfg_data  <= CFG_DATA_W'(alpha);
		sb.configure(CFG_ALPHA, CFG_DATA_W'(alpha));
		@(negedge clk);
		cfg_index <= CFG_THRESHOLD;
		cfg_data  <= CFG_DATA_W'(thresh);
		sb.configure(CFG_THRESHOLD, CFG_DATA_W'(thresh));
		@(negedge clk);
		cfg_index <= CFG_COUNT;
		cfg_data  <= CFG_DATA_W'(cnt);
		sb.configure(CFG_COUNT, CFG_DATA_W'(cnt));
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_random(int unsigned n_items);
		int unsigned taken;
		sample_word_t w;
		taken = 0;
		while (taken < n_items) begin
			w = pick_sample(sb.count);
			if (w.channel < sb.count)
				taken++;
			send_word(w);
		end
	endtask

	initial begin
		int unsigned n_items;
		sb = new();
		for (int i = 0; i < CHANNELS; i++)
			aim[i] = $urandom_range(0, 4095);
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: first reports, blocked reports, rails, falling steps
		send_word(mk(0, 4095, 1));
		send_word(mk(0, 4095, 1));
		send_word(mk(1, 0, 0));
		send_word(mk(1, 0, 1));
		send_word(mk(7, 4095, 0));
		send_word(mk(7, 4095, 1));
		send_word(mk(0, 0, 1));
		send_word(mk(3, 2730, 1));
		send_word(mk(2, 1365, 1));
		settle();

		// frozen filter, zero dead-band, three channels in use
		write_regs(0, 0, 3);
		send_word(mk(2, 4095, 1));
		send_word(mk(2, 4095, 1));
		send_word(mk(0, 0, 1));
		send_word(mk(5, 4095, 1));
		send_word(mk(4, 1234, 1));
		settle();

		// fastest filter, every move reported
		write_regs(65535, 0, 8);
		send_word(mk(6, 4095, 1));
		send_word(mk(6, 4095, 1));
		send_word(mk(6, 0, 1));
		send_word(mk(6, 1, 0));
		settle();

		// slowest filter, widest dead-band: only first reports get out
		write_regs(1, 16777215, 8);
		send_word(mk(4, 4095, 1));
		send_word(mk(4, 4095, 1));
		send_word(mk(5, 0, 1));
		settle();

		// no channels in use: everything dropped
		write_regs(6554, 167936, 0);
		repeat (20) send_word(pick_sample(8));
		settle();

		// random phases under a range of settings; the last runs with no idling
		for (int p = 0; p < 8; p++) begin
			n_items = 225;
			case (p)
				0: write_regs(65535, 0, 8);
				1: begin
					write_regs(1, 16777215, 8);
					n_items = 60;
				end
				2: write_regs($urandom_range(1, 65535), $urandom_range(0, 4096), 8);
				3: write_regs($urandom_range(1, 2048), $urandom_range(0, 1 << 18),
					$urandom_range(1, 8));
				4: write_regs($urandom_range(30000, 65535), $urandom_range(0, 1 << 20),
					$urandom_range(1, 8));
				5: write_regs(ALPHA_RST, THRESH_RST, 8);
				6: write_regs($urandom_range(1, 65535), $urandom_range(0, 1 << 16),
					$urandom_range(1, 7));
				default: begin
					quiet = 1'b1;
					write_regs($urandom_range(1, 65535), $urandom_range(0, 1 << 17), 8);
				end
			endcase
			run_random(n_items);
			settle();
		end

		repeat (10) @(negedge clk);
		if (sb.errors == 0 && sb.owed_knobs.size() == 0)
			$display("knob_smoothing_change_detector verification clean");
		else
			$display("knob_smoothing_change_detector verification failed");
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl
rtl/kscd_pkg.sv
rtl/kscd_front.sv
rtl/kscd_queue.sv
rtl/kscd_back.sv
rtl/knob_smoothing_change_detector.sv
rtl/kscd_checker.sv
tb/tb_knob_smoothing_change_detector.sv
